### design/sorted_table_interval_search_top_defines.svh
// Assertion macros for the sorted table interval search block.
// Used by the top level only; no other dependencies.
`ifndef SORTED_TABLE_INTERVAL_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_INTERVAL_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/sts_pkg.sv
// Package for the sorted table interval search block: item types, codes and defaults.
// Used by the top level and the testbench; depends on nothing.
package sts_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam int POS_W    = 11;
  localparam int ENTRY_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSIDE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABOVE  = 2'd2;

  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic                      command;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_PROBE,
    ST_RESULT
  } state_t;

endpackage

### design/sts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sorted_table_interval_search_top.sv
// Write items are accepted while idle. A query reads the first entry, the last entry and
// each probe as needed, one read per cycle on the single memory read port, then stages
// the result in ST_RESULT until the output takes it; no item is accepted meanwhile.
// Reset clears table_size and control state; table entries stay undefined.
module sorted_table_interval_search_top #(
  parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = sts_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sts_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sts_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sts_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [sts_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [sts_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import sts_pkg::*;
  `include "sorted_table_interval_search_top_defines.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int EXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;

  state_t                       state_r, state_nxt;
  logic signed [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [POS_W-1:0]             n_r, n_nxt;
  logic [POS_W-1:0]             lo_r, lo_nxt;
  logic [POS_W-1:0]             hi_r, hi_nxt;
  logic [POS_W-1:0]             mid_r, mid_nxt;
  out_item_t                    res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_data_r, out_data_nxt;
  logic [POS_W-1:0]             table_size_r, table_size_nxt;

  logic                         cfg_wr;
  logic                         in_fire;
  logic signed [63:0]           value_ext;
  logic signed [KEY_WIDTH-1:0]  in_key;
  logic [POS_W-1:0]             n_clip;
  logic [EXT_W-1:0]             waddr_ext;
  logic [EXT_W-1:0]             raddr_ext;
  logic [POS_W-1:0]             rd_pos;
  logic                         mem_we;
  logic                         mem_re;
  logic [KEY_WIDTH-1:0]         rd_data;
  logic signed [KEY_WIDTH-1:0]  entry;
  logic [POS_W:0]               span_sum;
  logic [POS_W:0]               lo_plus1;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TABLE_SIZE) ? DATA_W'(table_size_r) : '0;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign value_ext = {{(64 - VALUE_W){in_data.value[VALUE_W-1]}}, in_data.value};
  assign in_key    = value_ext[KEY_WIDTH-1:0];
  assign n_clip    = (32'(table_size_r) > 32'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                            : table_size_r;
  assign waddr_ext = EXT_W'(in_data.entry_index);
  assign raddr_ext = EXT_W'(rd_pos);
  assign mem_we    = in_fire && (in_data.command == CMD_WRITE)
                     && (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
  assign entry     = rd_data;

  sts_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr_ext[IDX_W-1:0]),
    .wdata (in_key),
    .re    (mem_re),
    .raddr (raddr_ext[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      table_size_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      table_size_r <= table_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    n_r        <= n_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    n_nxt          = n_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_data_nxt   = out_data_r;
    table_size_nxt = table_size_r;
    mem_re         = 1'b0;
    rd_pos         = '0;
    span_sum       = '0;
    lo_plus1       = '0;

    if (cfg_wr && (cfg_paddr[2] == REG_TABLE_SIZE)) begin
      table_size_nxt = cfg_pwdata[POS_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.command == CMD_QUERY)) begin
          key_nxt = in_key;
          n_nxt   = n_clip;
          if (n_clip == '0) begin
            res_nxt.position = '0;
            res_nxt.status   = STATUS_BELOW;
            state_nxt        = ST_RESULT;
          end else begin
            mem_re    = 1'b1;
            rd_pos    = '0;
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (key_r < entry) begin
          res_nxt.position = '0;
          res_nxt.status   = STATUS_BELOW;
          state_nxt        = ST_RESULT;
        end else if (n_r == POS_W'(1)) begin
          res_nxt.position = n_r;
          res_nxt.status   = STATUS_ABOVE;
          state_nxt        = ST_RESULT;
        end else begin
          mem_re    = 1'b1;
          rd_pos    = n_r - POS_W'(1);
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (key_r > entry) begin
          res_nxt.position = n_r;
          res_nxt.status   = STATUS_ABOVE;
          state_nxt        = ST_RESULT;
        end else begin
          lo_nxt = '0;
          hi_nxt = n_r - POS_W'(1);
        end
      end
      ST_PROBE: begin
        if (entry > key_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (((state_r == ST_LAST) && !(key_r > entry)) || (state_r == ST_PROBE)) begin
      lo_plus1 = {1'b0, lo_nxt} + (POS_W + 1)'(1);
      span_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
      if ({1'b0, hi_nxt} > lo_plus1) begin
        mid_nxt   = span_sum[POS_W:1];
        mem_re    = 1'b1;
        rd_pos    = span_sum[POS_W:1];
        state_nxt = ST_PROBE;
      end else begin
        res_nxt.position = lo_nxt;
        res_nxt.status   = STATUS_INSIDE;
        state_nxt        = ST_RESULT;
      end
    end
  end

  `STS_ASSERT_SAME(a_probe_span, clk, rst_n, (state_r == ST_PROBE),
                   (({1'b0, hi_r} > ({1'b0, lo_r} + (POS_W + 1)'(1))) && (mid_r > lo_r) && (mid_r < hi_r)))
  `STS_ASSERT_SAME(a_above_pos, clk, rst_n,
                   ((state_r == ST_RESULT) && (res_r.status == STATUS_ABOVE)),
                   (res_r.position == n_r))
  `STS_ASSERT_NEXT(a_query_busy, clk, rst_n, (in_fire && (in_data.command == CMD_QUERY)),
                   (state_r != ST_IDLE))

endmodule

### dv/sorted_table_interval_search_top_tb.sv
`timescale 1ns / 100ps
// Testbench for sorted_table_interval_search_top: loads key tables, queries intervals and checks
// every result against an in-bench binary search predictor. Depends on sts_pkg and the top level.
module sorted_table_interval_search_top_tb;
  import sts_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int KEY_MIN     = 32'sh8000_0000;
  localparam int KEY_MAX     = 32'sh7fff_ffff;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 250;
  localparam int FULL_LOAD_MAX = 64;

  class interval_checker;
    int keys [DEPTH];
    int unsigned size_reg;
    out_item_t awaited[$];
    int fails;

    function void set_size(int unsigned v);
      size_reg = v & 32'h7ff;
    endfunction

    function out_item_t locate_interval(int key);
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      out_item_t r;
      n = (size_reg > DEPTH) ? DEPTH : size_reg;
      if (n == 0 || key < keys[0]) begin
        r.position = '0;
        r.status = STATUS_BELOW;
      end else if (n < 2 || key > keys[n-1]) begin
        r.position = POS_W'(n);
        r.status = STATUS_ABOVE;
      end else begin
        lo = 0;
        hi = n - 1;
        while (hi > lo + 1) begin
          mid = (lo + hi) >> 1;
          if (keys[mid] > key) hi = mid;
          else lo = mid;
        end
        r.position = POS_W'(lo);
        r.status = STATUS_INSIDE;
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      if (it.command == CMD_WRITE) keys[it.entry_index] = int'(it.value);
      else awaited.push_back(locate_interval(int'(it.value)));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        fails++;
        $error("unexpected result: position %0d status %0d", got.position, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.position !== want.position) begin
        fails++;
        $error("position: expected %0d, actual %0d", want.position, got.position);
      end
      if (got.status !== want.status) begin
        fails++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  interval_checker book = new();
  int shadow [DEPTH];
  bit filled [DEPTH];
  int burst_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int quiet = 0;

  sorted_table_interval_search_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) book.note_item(in_data);
      if (out_valid && out_ready) book.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    @(posedge rst_n);
    forever begin
      if (holds_asked > holds_done) begin
        holds_done++;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic offer(input logic cmd, input int unsigned idx, input int val);
    in_item_t it;
    int gap;
    it.command = cmd;
    it.entry_index = ENTRY_W'(idx);
    it.value = val;
    if (cmd == CMD_WRITE) begin
      shadow[it.entry_index] = val;
      filled[it.entry_index] = 1'b1;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic touch(input int unsigned idx);
    if (!filled[idx]) offer(CMD_WRITE, idx, int'(idx) * 4096 - 2000000);
  endtask

  // Unwritten entries on the search path of a large table are written just before the query.
  task automatic prepare_path(input int unsigned n, input int key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (n == 0) return;
    touch(0);
    if (key < shadow[0] || n < 2) return;
    touch(n - 1);
    if (key > shadow[n - 1]) return;
    lo = 0;
    hi = n - 1;
    while (hi > lo + 1) begin
      mid = (lo + hi) >> 1;
      touch(mid);
      if (shadow[mid] > key) hi = mid;
      else lo = mid;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_table_size(input int unsigned v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_W'(4 * int'(REG_TABLE_SIZE));
    cfg_pwdata <= DATA_W'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    book.set_size(v);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_table(input int unsigned n);
    int vals[$];
    int unsigned style;
    int unsigned i;
    style = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      case (style)
        0: vals.push_back(int'($urandom));
        1: vals.push_back(int'($urandom_range(0, 16)) - 8);
        2: vals.push_back(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        default: vals.push_back(int'($urandom));
      endcase
    end
    vals.sort();
    if (style == 3 && n >= 2) begin
      vals[0] = KEY_MIN;
      vals[n-1] = KEY_MAX;
    end
    foreach (vals[k]) offer(CMD_WRITE, k, vals[k]);
  endtask

  task automatic random_item(input int unsigned n);
    int unsigned pick;
    int unsigned idx;
    int key;
    pick = $urandom_range(0, 99);
    if (pick >= 60 && pick < 85 && n > 0) begin
      // Copying a neighbor keeps the table ascending.
      idx = $urandom_range(0, n - 1);
      if (idx > 0 && $urandom_range(0, 1) == 1) key = shadow[idx-1];
      else if (idx + 1 < n) key = shadow[idx+1];
      else key = shadow[idx];
      offer(CMD_WRITE, idx, key);
    end else if (pick >= 85 && pick < 93) begin
      offer(CMD_WRITE, $urandom_range(0, DEPTH - 1), int'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0: key = int'($urandom);
        1: key = (n > 0) ? shadow[$urandom_range(0, n - 1)] : 0;
        2: key = (n > 0) ? shadow[$urandom_range(0, n - 1)] + 1 : KEY_MIN;
        3: key = (n > 0) ? shadow[$urandom_range(0, n - 1)] - 1 : KEY_MAX;
        4: key = ($urandom_range(0, 1) == 1) ? KEY_MIN : KEY_MAX;
        default: key = int'($urandom_range(0, 40)) - 20;
      endcase
      prepare_path(n, key);
      offer(CMD_QUERY, $urandom_range(0, DEPTH - 1), key);
    end
  endtask

  initial begin : stimulus
    int four_keys [4];
    int probes [8];
    int unsigned n_cfg;
    int unsigned n_eff;
    int unsigned phase;
    int unsigned count;
    int unsigned random_done;
    four_keys = '{-1000, -7, 40, 900};
    probes = '{-1001, -1000, 39, 40, 900, 901, KEY_MIN, KEY_MAX};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    set_table_size(0);
    offer(CMD_QUERY, 0, KEY_MIN);
    offer(CMD_QUERY, DEPTH - 1, KEY_MAX);
    settle();
    set_table_size(1);
    offer(CMD_WRITE, 0, 100);
    offer(CMD_QUERY, 0, 50);
    offer(CMD_QUERY, 0, 100);
    offer(CMD_QUERY, 0, 200);
    settle();
    set_table_size(4);
    foreach (four_keys[k]) offer(CMD_WRITE, k, four_keys[k]);
    foreach (probes[k]) offer(CMD_QUERY, 0, probes[k]);
    // An out-of-order entry still runs the normal search.
    offer(CMD_WRITE, 2, -2000);
    offer(CMD_QUERY, 0, 0);

    random_done = 0;
    phase = 0;
    while (random_done < RANDOM_ITEMS) begin
      settle();
      case (phase)
        1: n_cfg = DEPTH;
        3: n_cfg = 2047;
        5: n_cfg = $urandom_range(DEPTH + 1, 2046);
        7: n_cfg = 0;
        default: begin
          n_cfg = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
        end
      endcase
      set_table_size(n_cfg);
      n_eff = (n_cfg > DEPTH) ? DEPTH : n_cfg;
      if (phase == 2) holds_asked++;
      if (n_eff <= FULL_LOAD_MAX) begin
        load_table(n_eff);
        count = $urandom_range(15, 35);
      end else begin
        count = $urandom_range(8, 12);
      end
      repeat (count) begin
        random_item(n_eff);
        random_done++;
      end
      phase++;
    end
    settle();
    if (book.fails == 0 && book.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/sts_pkg.sv
design/sts_ram.sv
design/sorted_table_interval_search_top.sv
dv/sorted_table_interval_search_top_tb.sv
